### hw/rtl/mbrx_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU receiver.
// No dependencies; used by the stage modules and the top level.
`default_nettype none

package mbrx_pkg;

  localparam logic [8:0]  MAX_FRAME   = 9'd256;
  localparam logic [8:0]  COUNT_SAT   = 9'd511;
  localparam logic [8:0]  REQ_LEN     = 9'd8;
  localparam logic [7:0]  FUNC_LIMIT  = 8'd127;
  localparam logic [7:0]  REQ_FUNC_LO = 8'h01;
  localparam logic [7:0]  REQ_FUNC_HI = 8'h04;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam logic       RST_SLAVE_MODE    = 1'b1;
  localparam logic [7:0] RST_STATION_ID    = 8'd1;
  localparam logic [7:0] RST_SILENCE_TICKS = 8'd35;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_MODE    = 2'd0,
    CFG_STATION_ID    = 2'd1,
    CFG_SILENCE_TICKS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       frame_good;
    logic       addr_error;
    logic       length_error;
    logic       function_error;
    logic       req_len_error;
    logic       crc_error;
    logic [8:0] frame_length;
    logic [7:0] station_address;
    logic [7:0] function_code;
  } result_t;

  typedef struct packed {
    logic       slave_mode;
    logic [7:0] station_id;
    logic [7:0] silence_ticks;
  } cfg_t;

  // Input stage to frame logic
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // Reflected CRC-16 (0xA001), one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mbrx_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from mbrx_pkg at instantiation.
`default_nettype none

interface mbrx_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/mbrx_in_stage.sv
// Input register for the receiver: holds one accepted byte/tick transaction.
// Depends on mbrx_pkg and mbrx_stream_if.
`default_nettype none

module mbrx_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  mbrx_stream_if.sink      rx_i,
  input  logic             advance_i,
  output mbrx_pkg::stage_t stage_o
);
  import mbrx_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign rx_i.ready = !valid_q || advance_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= rx_i.data;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

`default_nettype wire

### hw/rtl/mbrx_frame_ctrl.sv
// Frame state, on-the-fly CRC, end-of-frame checks and the result register.
// Depends on mbrx_pkg and mbrx_stream_if.
`default_nettype none

module mbrx_frame_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mbrx_pkg::cfg_t   cfg_i,
  input  mbrx_pkg::stage_t stage_i,
  output logic             advance_o,
  mbrx_stream_if.source    res_o
);
  import mbrx_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [15:0] held_q, held_d;
  logic [8:0]  count_q, count_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  func_q, func_d;
  logic [7:0]  silence_q, silence_d;
  logic        timer_q, timer_d;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;
  logic        fire;
  logic        frame_end;
  logic        tick_end;
  logic        ae, le, fe, fb, crc_match;

  // Only a tick that closes a frame needs the result register free
  assign tick_end  = stage_i.valid && (stage_i.item.action == ACT_TICK) && timer_q
                     && (({1'b0, silence_q} + 9'd1) > {1'b0, cfg_i.silence_ticks});
  assign advance_o = !out_valid_q || res_o.ready || !tick_end;
  assign fire      = stage_i.valid && advance_o;

  // End-of-frame checks on the current frame state
  always_comb begin
    ae = cfg_i.slave_mode && (addr_q != cfg_i.station_id);
    le = count_q > MAX_FRAME;
    fe = func_q > FUNC_LIMIT;
    fb = !fe && cfg_i.slave_mode && (func_q >= REQ_FUNC_LO) && (func_q <= REQ_FUNC_HI)
         && (count_q != REQ_LEN);
    crc_match = (count_q > 9'd2) && (held_q[15:8] == crc_q[7:0])
                && (held_q[7:0] == crc_q[15:8]);
  end

  always_comb begin
    crc_d       = crc_q;
    held_d      = held_q;
    count_d     = count_q;
    addr_d      = addr_q;
    func_d      = func_q;
    silence_d   = silence_q;
    timer_d     = timer_q;
    frame_end   = 1'b0;
    out_valid_d = out_valid_q && !res_o.ready;

    res_d.frame_good      = !(ae || le || fe || fb) && crc_match;
    res_d.addr_error      = ae;
    res_d.length_error    = le;
    res_d.function_error  = fe;
    res_d.req_len_error   = fb;
    res_d.crc_error       = !(ae || le || fe || fb) && !crc_match;
    res_d.frame_length    = count_q;
    res_d.station_address = addr_q;
    res_d.function_code   = func_q;

    if (fire) begin
      case (action_e'(stage_i.item.action))
        ACT_BYTE: begin
          if (count_q == 9'd0) begin
            addr_d = stage_i.item.rx_byte;
          end else if (count_q == 9'd1) begin
            func_d = stage_i.item.rx_byte;
          end
          // CRC lags two bytes behind; the last two are the check bytes
          if (count_q >= 9'd2) begin
            crc_d = crc16_byte(crc_q, held_q[15:8]);
          end
          held_d = {held_q[7:0], stage_i.item.rx_byte};
          if (count_q < COUNT_SAT) begin
            count_d = count_q + 9'd1;
          end
          silence_d = 8'd0;
          timer_d   = 1'b1;
        end
        ACT_TICK: begin
          if (timer_q) begin
            if (({1'b0, silence_q} + 9'd1) <= {1'b0, cfg_i.silence_ticks}) begin
              silence_d = silence_q + 8'd1;
            end else begin
              frame_end = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (frame_end) begin
      out_valid_d = 1'b1;
      crc_d       = CRC_INIT;
      held_d      = 16'h0000;
      count_d     = 9'd0;
      addr_d      = 8'd0;
      func_d      = 8'd0;
      silence_d   = 8'd0;
      timer_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      held_q      <= 16'h0000;
      count_q     <= 9'd0;
      addr_q      <= 8'd0;
      func_q      <= 8'd0;
      silence_q   <= 8'd0;
      timer_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      held_q      <= held_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      func_q      <= func_d;
      silence_q   <= silence_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

  // A frame is open exactly when bytes have been counted
  a_timer_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    timer_q == (count_q != 9'd0))
    else $error("timer state disagrees with byte count");

  a_idle_silence_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !timer_q |-> (silence_q == 8'd0) && (crc_q == CRC_INIT))
    else $error("idle receiver holds stale frame state");

  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire && stage_i.item.action == ACT_TICK))
    else $error("result produced without an ending tick");

  a_status_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({res_q.frame_good, res_q.crc_error})
                    && !(res_q.frame_good && (res_q.addr_error || res_q.length_error
                         || res_q.function_error || res_q.req_len_error)))
    else $error("inconsistent frame status flags");

endmodule

`default_nettype wire

### hw/rtl/modbus_rtu_frame_receiver_core.sv
// Modbus RTU frame receiver top level: config registers, input stage, frame logic.
// Depends on mbrx_pkg, mbrx_stream_if, mbrx_in_stage and mbrx_frame_ctrl.
//
//   channel  dir  payload                      notes
//   rx_i     in   item_t  {action, rx_byte}    byte (action 0) or 0.1 ms tick
//   res_o    out  result_t status + fields     one per ended frame
//   cfg_*    in   idx/data, write enable       slave_mode, station_id, silence_ticks
//
// One transaction per cycle sustained but for the stall below; an ending tick goes
// through the input register and the result register to res_o. While a result waits,
// only a tick that would end the next frame stalls in the input register; other bytes
// and ticks keep flowing. Reset returns the frame state to idle and the registers to
// their defaults. No clearing pass after reset.
`default_nettype none

module modbus_rtu_frame_receiver_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mbrx_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mbrx_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  mbrx_stream_if.sink                        rx_i,
  mbrx_stream_if.source                      res_o
);
  import mbrx_pkg::*;

  cfg_t   cfg_q;
  stage_t stage;
  logic   advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_mode    <= RST_SLAVE_MODE;
      cfg_q.station_id    <= RST_STATION_ID;
      cfg_q.silence_ticks <= RST_SILENCE_TICKS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SLAVE_MODE:    cfg_q.slave_mode    <= cfg_data_i[0];
        CFG_STATION_ID:    cfg_q.station_id    <= cfg_data_i;
        CFG_SILENCE_TICKS: cfg_q.silence_ticks <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mbrx_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  mbrx_frame_ctrl u_frame_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .stage_i   (stage),
    .advance_o (advance),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

### sim/mbrx_tb_pkg.sv
// Testbench helpers for the Modbus RTU receiver: table-form CRC-16 step.
// Depends on mbrx_pkg for the polynomial; used by the checker and the tb top.
package mbrx_tb_pkg;

  // Table-driven update, entries computed on demand from the low index byte
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] entry;
    entry = {8'h00, crc[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      entry = entry[0] ? ((entry >> 1) ^ mbrx_pkg::CRC_POLY) : (entry >> 1);
    end
    return (crc >> 8) ^ entry;
  endfunction

endpackage

### sim/mbrx_frame_checker.sv
// Frame status predictor and scoreboard for modbus_rtu_frame_receiver_core.
// Watches the config port and both stream channels; depends on mbrx_pkg,
// mbrx_tb_pkg and mbrx_stream_if.
module mbrx_frame_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mbrx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mbrx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mbrx_stream_if                          rx_mon,
  mbrx_stream_if                          res_mon,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mbrx_pkg::*;
  import mbrx_tb_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  cfg_t        regs;
  logic [15:0] crc_acc;
  logic [15:0] tail_bytes;   // last two bytes, not yet in the CRC
  logic [8:0]  nbytes;
  logic [7:0]  addr_byte;
  logic [7:0]  func_byte;
  logic [7:0]  quiet_ticks;
  logic        frame_open;

  result_t     status_q[$];
  int unsigned fails = 0;
  int unsigned reported = 0;

  task automatic clear_frame();
    crc_acc     = CRC_INIT;
    tail_bytes  = '0;
    nbytes      = '0;
    addr_byte   = '0;
    func_byte   = '0;
    quiet_ticks = '0;
    frame_open  = 1'b0;
  endtask

  function automatic result_t frame_status();
    result_t r;
    logic    clean;
    r.addr_error      = regs.slave_mode && (addr_byte != regs.station_id);
    r.length_error    = nbytes > MAX_FRAME;
    r.function_error  = func_byte > FUNC_LIMIT;
    r.req_len_error   = !r.function_error && regs.slave_mode && func_byte >= REQ_FUNC_LO &&
                        func_byte <= REQ_FUNC_HI && nbytes != REQ_LEN;
    clean             = !(r.addr_error || r.length_error || r.function_error ||
                          r.req_len_error);
    // CRC travels low byte first
    r.frame_good      = clean && nbytes > 9'd2 && tail_bytes == {crc_acc[7:0], crc_acc[15:8]};
    r.crc_error       = clean && !r.frame_good;
    r.frame_length    = nbytes;
    r.station_address = addr_byte;
    r.function_code   = func_byte;
    return r;
  endfunction

  task automatic take_item(input item_t it);
    if (it.action == ACT_BYTE) begin
      if (nbytes == 9'd0) begin
        addr_byte = it.rx_byte;
      end else if (nbytes == 9'd1) begin
        func_byte = it.rx_byte;
      end
      if (nbytes >= 9'd2) begin
        crc_acc = crc16_next(crc_acc, tail_bytes[15:8]);
      end
      tail_bytes = {tail_bytes[7:0], it.rx_byte};
      if (nbytes != COUNT_SAT) begin
        nbytes++;
      end
      quiet_ticks = '0;
      frame_open  = 1'b1;
    end else if (frame_open) begin
      if ({1'b0, quiet_ticks} + 9'd1 <= {1'b0, regs.silence_ticks}) begin
        quiet_ticks++;
      end else begin
        status_q.push_back(frame_status());
        clear_frame();
      end
    end
  endtask

  function automatic string show(input result_t r);
    return $sformatf("ok=%0b ae=%0b le=%0b fe=%0b fb=%0b ce=%0b len=%0d addr=%02h fc=%02h",
                     r.frame_good, r.addr_error, r.length_error, r.function_error,
                     r.req_len_error, r.crc_error, r.frame_length, r.station_address,
                     r.function_code);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      regs.slave_mode    = RST_SLAVE_MODE;
      regs.station_id    = RST_STATION_ID;
      regs.silence_ticks = RST_SILENCE_TICKS;
      clear_frame();
      status_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got = res_mon.data;
        if (status_q.size() == 0) begin
          fails++;
          if (reported < REPORT_MAX) begin
            reported++;
            $display("%0t unexpected status: %s", $realtime, show(got));
          end
        end else begin
          want = status_q.pop_front();
          // packed compare covers every field
          if (got !== want) begin
            fails++;
            if (reported < REPORT_MAX) begin
              reported++;
              $display("%0t status mismatch\n  exp %s\n  got %s", $realtime, show(want),
                       show(got));
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SLAVE_MODE:    regs.slave_mode    = cfg_data_i[0];
          CFG_STATION_ID:    regs.station_id    = cfg_data_i;
          CFG_SILENCE_TICKS: regs.silence_ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (rx_mon.valid && rx_mon.ready) begin
        take_item(rx_mon.data);
      end
      fail_count_o <= fails;
      pending_o    <= status_q.size();
    end
  end

endmodule

### sim/tb.sv
// Top of the Modbus RTU receiver testbench: clock, reset, config writes and
// byte/tick stimulus, result back-pressure, watchdog and verdict.
// Depends on mbrx_pkg, mbrx_tb_pkg, mbrx_stream_if and mbrx_frame_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrx_pkg::*;
  import mbrx_tb_pkg::*;

  localparam int RST_CYCLES     = 4;
  localparam int DRAIN_CYCLES   = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_GOAL      = 1800;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;

  logic        cur_slave;
  logic [7:0]  cur_sid;
  int          cur_sil;
  int          gap_pct;
  logic        calm        = 1'b0;
  logic        hold_req    = 1'b0;
  logic        whole_frame = 1'b0;
  int          n_items  = 0;
  logic [7:0]  frame_q[$];
  int unsigned idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  mbrx_stream_if #(.payload_t(item_t))   rx_if ();
  mbrx_stream_if #(.payload_t(result_t)) res_if ();

  modbus_rtu_frame_receiver_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  mbrx_frame_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .rx_mon       (rx_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result side back-pressure
  initial begin
    int stall;
    int run;
    stall = 0;
    run = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (calm || run > 0) begin
        res_if.ready <= 1'b1;
        if (run > 0) run--;
      end else if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        case ($urandom_range(9))
          0: begin
            stall = $urandom_range(6);
            res_if.ready <= 1'b0;
          end
          1: begin
            run = $urandom_range(20, 60);
            res_if.ready <= 1'b1;
          end
          default: res_if.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // One transaction on rx_if; returns at the accepting edge
  task automatic put_item(input action_e act, input logic [7:0] b);
    item_t it;
    it.action  = act;
    it.rx_byte = (act == ACT_BYTE) ? b : 8'($urandom);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < gap_pct) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.data  <= it;
    do @(posedge clk_i); while (!rx_if.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
  endtask

  task automatic cfg_release();
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic slv, input logic [7:0] sid, input int sil);
    drain();
    cfg_write(CFG_SLAVE_MODE, {7'd0, slv});
    cfg_write(CFG_STATION_ID, sid);
    cfg_write(CFG_SILENCE_TICKS, 8'(sil));
    cfg_release();
    cur_slave = slv;
    cur_sid   = sid;
    cur_sil   = sil;
  endtask

  task automatic add_crc();
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (frame_q[i]) crc = crc16_next(crc, frame_q[i]);
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endtask

  // frame_q bytes with silence below the limit or a splitting gap, then end gap
  task automatic send_frame();
    int t;
    foreach (frame_q[i]) begin
      if (i != 0 && !whole_frame && cur_sil > 0 && $urandom_range(3) == 0) begin
        t = $urandom_range(1, (cur_sil < 4) ? cur_sil : 4);
        repeat (t) put_item(ACT_TICK, 8'h00);
        n_items += t;
      end else if (i != 0 && !whole_frame && $urandom_range(49) == 0) begin
        // gap long enough to split the frame in two
        repeat (cur_sil + 1) put_item(ACT_TICK, 8'h00);
        n_items += cur_sil + 1;
      end
      put_item(ACT_BYTE, frame_q[i]);
      n_items++;
    end
    repeat (cur_sil + 1) put_item(ACT_TICK, 8'h00);
    n_items += cur_sil + 1;
    // stray ticks while idle
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) put_item(ACT_TICK, 8'h00);
    end
  endtask

  task automatic build_frame();
    int         kind;
    int         nd;
    int         pos;
    logic [7:0] addr;
    logic [7:0] func;
    logic       corrupt;
    kind    = $urandom_range(99);
    addr    = (cur_slave && $urandom_range(7) != 0) ? cur_sid : 8'($urandom);
    func    = 8'($urandom_range(REQ_FUNC_LO, REQ_FUNC_HI));
    nd      = 4;
    corrupt = 1'b0;
    frame_q.delete();
    if (kind >= 90) begin
      // short frames and plain noise
      nd = (kind < 95) ? $urandom_range(1, 3) : $urandom_range(1, 12);
      repeat (nd) frame_q.push_back(8'($urandom));
      if ($urandom_range(1) != 0) frame_q[0] = cur_sid;
      return;
    end
    if (kind < 40) begin
      // read/write request, eight bytes
    end else if (kind < 65) begin
      func = 8'($urandom_range(FUNC_LIMIT));
      nd   = (func >= REQ_FUNC_LO && func <= REQ_FUNC_HI) ? 4 : $urandom_range(12);
    end else if (kind < 75) begin
      corrupt = 1'b1;
    end else if (kind < 80) begin
      addr = cur_sid ^ 8'($urandom_range(1, 255));
    end else if (kind < 85) begin
      func = 8'($urandom_range(255, FUNC_LIMIT + 1));
      nd   = $urandom_range(6);
    end else begin
      nd = $urandom_range(8);
      if (nd == 4) nd = 5;
    end
    frame_q.push_back(addr);
    frame_q.push_back(func);
    repeat (nd) frame_q.push_back(8'($urandom));
    add_crc();
    if (corrupt) begin
      pos = $urandom_range(frame_q.size() - 1);
      frame_q[pos] ^= 8'(1 << $urandom_range(7));
    end
  endtask

  task automatic build_long(input int total);
    frame_q.delete();
    frame_q.push_back(cur_sid);
    frame_q.push_back(8'h10);
    repeat (total - 4) frame_q.push_back(8'($urandom));
    add_crc();
  endtask

  task automatic run_phase(input logic slv, input logic [7:0] sid, input int sil,
                           input int nframes, input int gp);
    set_config(slv, sid, sil);
    gap_pct = gp;
    repeat (nframes) begin
      build_frame();
      send_frame();
    end
  endtask

  initial begin
    logic       slv;
    logic [7:0] sid;
    int         sil;
    int         gp;
    rx_if.valid = 1'b0;
    rx_if.data  = '0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_SLAVE_MODE;
    cfg_data    = '0;
    cur_slave   = RST_SLAVE_MODE;
    cur_sid     = RST_STATION_ID;
    cur_sil     = RST_SILENCE_TICKS;
    gap_pct     = 0;
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ticks while idle, zero silence, good request, one-byte frame,
    // bad function code, station id changed in the middle of a frame
    put_item(ACT_TICK, 8'h00);
    put_item(ACT_TICK, 8'hFF);
    set_config(1'b1, RST_STATION_ID, 0);
    frame_q = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01};
    add_crc();
    send_frame();
    frame_q = '{8'hFF};
    send_frame();
    frame_q = '{8'h01, 8'hFF};
    send_frame();
    frame_q = '{8'h05, 8'h10};
    add_crc();
    put_item(ACT_BYTE, frame_q[0]);
    put_item(ACT_BYTE, frame_q[1]);
    drain();
    cfg_write(CFG_STATION_ID, 8'h05);
    cfg_release();
    cur_sid = 8'h05;
    put_item(ACT_BYTE, frame_q[2]);
    put_item(ACT_BYTE, frame_q[3]);
    put_item(ACT_TICK, 8'h00);

    // Random frames over a spread of settings
    run_phase(1'b0, 8'h00, 1, 8, 20);
    run_phase(1'b1, 8'hFF, 3, 8, 10);
    run_phase(1'b1, 8'h00, 0, 10, 0);

    // Result side held off while frames keep coming
    set_config(1'b1, 8'($urandom), 1);
    gap_pct = 0;
    hold_req = 1'b1;
    repeat (10) begin
      build_frame();
      send_frame();
    end

    // Length limit boundary and count saturation, sent without silence inside
    set_config(1'b0, 8'h2A, 2);
    gap_pct = 10;
    whole_frame = 1'b1;
    build_long(int'(MAX_FRAME));
    send_frame();
    build_long(int'(MAX_FRAME) + 1);
    send_frame();
    set_config(1'b1, 8'h2A, 1);
    build_long(520);
    send_frame();
    whole_frame = 1'b0;

    run_phase(1'b1, 8'h80, 255, 1, 10);

    while (n_items < ITEM_GOAL) begin
      slv = 1'($urandom_range(1));
      case ($urandom_range(3))
        0:       sid = 8'h00;
        1:       sid = 8'hFF;
        default: sid = 8'($urandom);
      endcase
      case ($urandom_range(9))
        0:       sil = 0;
        1:       sil = $urandom_range(7, 20);
        default: sil = $urandom_range(1, 4);
      endcase
      case ($urandom_range(2))
        0:       gp = 0;
        1:       gp = 10;
        default: gp = 30;
      endcase
      run_phase(slv, sid, sil, $urandom_range(8, 20), gp);
    end

    // Final stretch at full rate on both sides
    calm = 1'b1;
    run_phase(1'b1, 8'($urandom), 2, 10, 0);

    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
